[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fwat_pkg.sv]
package fwat_pkg;

    // queue geometry
    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int OCC_W = 5;

    localparam logic [7:0] TIMEOUT_RESET = 8'd21;

    // one queued record, task id in the lowest bits
    typedef struct packed {
        logic [7:0]  wait_cnt;
        logic [15:0] remaining;
        logic [2:0]  prio;
        logic [15:0] task_id;
    } t_rec;

    localparam int REC_W      = $bits(t_rec);
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - REC_W - OCC_W - 1;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_POPPED    = 3'd0,
        KIND_POP_EMPTY = 3'd1,
        KIND_TIMEOUT   = 3'd2,
        KIND_PUSH_OK   = 3'd3,
        KIND_PUSH_FULL = 3'd4,
        KIND_TICK_DONE = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_TICK,
        ST_TDONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  push_wr;
        logic  pop_rd;
        logic  pop_done;
        logic  tick_start;
        logic  tick_step;
        logic  out_load;
        t_kind out_kind;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic full;
        logic evict;
        logic tick_end;
    } t_dp_stat;

    // circular pointer plus offset, offset at most DEPTH
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // occupancy masked to its result field
    function automatic logic [OCC_W-1:0] occ_field(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] ext;
        ext = {{OCC_W{1'b0}}, cnt};
        return ext[OCC_W-1:0];
    endfunction

endpackage

[rtl/fwat_ram.sv]
module fwat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/fwat_dp.sv]
module fwat_dp
    import fwat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  t_rec             i_in_rec,
    input  logic             i_cfg_valid,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_kind            o_out_kind,
    output t_rec             o_out_rec,
    output logic [OCC_W-1:0] o_out_occ,
    output logic             o_out_empty,
    output logic             o_out_last
);

    logic [7:0]       r_limit, n_limit;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic [CNT_W-1:0] r_held, n_held;

    logic             r_out_valid, n_out_valid;
    t_kind            r_out_kind, n_out_kind;
    t_rec             r_out_rec, n_out_rec;
    logic [OCC_W-1:0] r_out_occ, n_out_occ;
    logic             r_out_empty, n_out_empty;
    logic             r_out_last, n_out_last;

    logic             w_wr_en;
    logic [PTR_W-1:0] w_wr_addr;
    t_rec             w_wr_data;
    logic             w_rd_en;
    logic [PTR_W-1:0] w_rd_addr;
    logic [REC_W-1:0] w_rd_raw;
    t_rec             w_rd_rec;
    t_rec             w_aged_rec;
    logic             w_evict;
    logic             w_out_free;

    // record store, circular from r_head
    fwat_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    assign w_rd_rec = w_rd_raw;

    // aging with saturation and timeout compare
    always_comb begin
        w_aged_rec = w_rd_rec;
        if (w_rd_rec.wait_cnt != 8'hFF) begin
            w_aged_rec.wait_cnt = w_rd_rec.wait_cnt + 8'd1;
        end
    end

    assign w_evict    = (w_aged_rec.wait_cnt >= r_limit);
    assign w_out_free = !r_out_valid || i_out_ready;

    // memory ports
    always_comb begin
        w_wr_en   = i_cmd.push_wr || (i_cmd.tick_step && !w_evict);
        w_wr_addr = i_cmd.push_wr ? wrap_add(r_head, r_count) : wrap_add(r_head, r_wr);
        w_wr_data = i_cmd.push_wr ? i_in_rec : w_aged_rec;
        w_rd_en   = i_cmd.pop_rd || i_cmd.tick_start || i_cmd.tick_step;
        w_rd_addr = i_cmd.tick_step ? wrap_add(r_head, r_rd + CNT_W'(1)) : r_head;
    end

    // pointers, counters and limit register
    always_comb begin
        n_limit = r_limit;
        n_head  = r_head;
        n_count = r_count;
        n_rd    = r_rd;
        n_wr    = r_wr;
        n_held  = r_held;
        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end
        if (i_cmd.push_wr) begin
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.pop_done) begin
            n_count = r_count - CNT_W'(1);
            n_head  = wrap_add(r_head, CNT_W'(1));
        end
        if (i_cmd.tick_start) begin
            n_rd   = '0;
            n_wr   = '0;
            n_held = r_count;
        end
        if (i_cmd.tick_step) begin
            n_rd = r_rd + CNT_W'(1);
            if (w_evict) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                n_wr = r_wr + CNT_W'(1);
            end
        end
    end

    // output word register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_rec   = r_out_rec;
        n_out_occ   = r_out_occ;
        n_out_empty = r_out_empty;
        n_out_last  = r_out_last;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_out_kind  = i_cmd.out_kind;
            n_out_occ   = occ_field(n_count);
            n_out_empty = (n_count == '0);
            n_out_last  = (i_cmd.out_kind != KIND_TIMEOUT);
            unique case (i_cmd.out_kind)
                KIND_POPPED:  n_out_rec = w_rd_rec;
                KIND_TIMEOUT: n_out_rec = w_aged_rec;
                default:      n_out_rec = '0;
            endcase
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= TIMEOUT_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_limit     <= n_limit;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_rec   <= n_out_rec;
        r_out_occ   <= n_out_occ;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    // status to controller
    always_comb begin
        o_stat.out_free   = w_out_free;
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = (r_count == CNT_W'(DEPTH));
        o_stat.evict      = w_evict;
        o_stat.tick_end   = ((r_rd + CNT_W'(1)) == r_held);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_rec   = r_out_rec;
    assign o_out_occ   = r_out_occ;
    assign o_out_empty = r_out_empty;
    assign o_out_last  = r_out_last;

endmodule

[rtl/fwat_ctrl.sv]
module fwat_ctrl
    import fwat_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_in_cmd,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   w_accept;
    logic   w_advance;

    assign o_in_ready = (r_state == ST_IDLE) && i_stat.out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    // a surviving entry never waits on the output side
    assign w_advance  = !i_stat.evict || i_stat.out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_cmd == CMD_POP && !i_stat.count_zero) begin
                    n_state = ST_POP;
                end else if (w_accept && i_in_cmd == CMD_TICK) begin
                    n_state = i_stat.count_zero ? ST_TDONE : ST_TICK;
                end
            end
            ST_POP: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (w_advance && i_stat.tick_end) begin
                    n_state = ST_TDONE;
                end
            end
            ST_TDONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_cmd)
                        CMD_PUSH: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_kind = KIND_PUSH_FULL;
                            end else begin
                                o_cmd.push_wr  = 1'b1;
                                o_cmd.out_kind = KIND_PUSH_OK;
                            end
                        end
                        CMD_POP: begin
                            if (i_stat.count_zero) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = KIND_POP_EMPTY;
                            end else begin
                                o_cmd.pop_rd = 1'b1;
                            end
                        end
                        CMD_TICK: o_cmd.tick_start = 1'b1;
                        CMD_NONE: o_cmd = '0;
                        default:  o_cmd = '0;
                    endcase
                end
            end
            ST_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_done = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = KIND_POPPED;
                end
            end
            ST_TICK: begin
                if (w_advance) begin
                    o_cmd.tick_step = 1'b1;
                    if (i_stat.evict) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = KIND_TIMEOUT;
                    end
                end
            end
            ST_TDONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = KIND_TICK_DONE;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/fifo_with_aging_timeout.sv]
// push and pop-on-empty results are loaded into the output register as the word is taken;
// a pop result passes the store read register, then the output register
// tick: a read-ahead of the head entry, then each held entry in turn on the store port, then the done word;
// a tick step waits only while a timeout word cannot be loaded into the output register
// the next word is taken once the controller is back idle and the output register can load
// reset (synchronous, active low) empties the queue, sets timeout_limit to 21, drops output valid
module fifo_with_aging_timeout
    import fwat_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // task_id[15:0], priority_req[18:16], remaining_time[34:19], initial_wait[42:35], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]            i_s_axis_tuser,
    // result words
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_task_id[15:0], out_priority[18:16], out_remaining[34:19], out_wait[42:35],
    // occupancy[47:43], is_empty[48], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // kind[2:0]
    output logic [2:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tlast,
    // timeout_limit write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_data
);

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    t_rec             w_in_rec;
    t_rec             w_out_rec;
    t_kind            w_out_kind;
    logic [OCC_W-1:0] w_out_occ;
    logic             w_out_empty;

    // unpack the pushed record
    assign w_in_rec = i_s_axis_tdata[REC_W-1:0];

    fwat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (t_cmd'(i_s_axis_tuser)),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fwat_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_rec    (w_in_rec),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (w_out_kind),
        .o_out_rec   (w_out_rec),
        .o_out_occ   (w_out_occ),
        .o_out_empty (w_out_empty),
        .o_out_last  (o_m_axis_tlast)
    );

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // pack the result word
    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_out_empty, w_out_occ, w_out_rec};
    assign o_m_axis_tuser = w_out_kind;

endmodule

[rtl/fwat_checker.sv]
`include "assert_macros.svh"

module fwat_checker
    import fwat_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [2:0]            o_m_axis_tuser,
    input logic                  o_m_axis_tlast
);

    logic [OCC_W-1:0] w_occ;
    logic             w_empty;
    logic             w_rec_kind;

    assign w_occ      = o_m_axis_tdata[REC_W+OCC_W-1:REC_W];
    assign w_empty    = o_m_axis_tdata[REC_W+OCC_W];
    assign w_rec_kind = (o_m_axis_tuser == KIND_POPPED) || (o_m_axis_tuser == KIND_TIMEOUT);

    // only timed-out words leave a tick open
    `ASSERT_NOW(a_last_kind, i_clk, i_rst_n, o_m_axis_tvalid, ((o_m_axis_tuser == KIND_TIMEOUT) ^ o_m_axis_tlast), "last flag disagrees with result kind")

    // empty flag implies no entries
    `ASSERT_NOW(a_empty_occ, i_clk, i_rst_n, o_m_axis_tvalid && w_empty, w_occ == '0, "empty flag set with entries held")

    // occupancy stays within the queue depth
    `ASSERT_NOW(a_occ_range, i_clk, i_rst_n, o_m_axis_tvalid, w_occ <= DEPTH, "occupancy beyond depth")

    // words without a record carry a zero record
    `ASSERT_NOW(a_rec_zero, i_clk, i_rst_n, o_m_axis_tvalid && !w_rec_kind, o_m_axis_tdata[REC_W-1:0] == '0, "record fields set on a status word")

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled result word changed")

endmodule

bind fifo_with_aging_timeout fwat_checker u_fwat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fwat_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    // leave margin past the longest tick for words still in flight
    localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int unsigned BURST_PUSHES = DEPTH + 2;

    // one result word as the queue should report it
    typedef struct {
        t_kind       kind;
        t_rec        rec;
        logic [4:0]  occ;
        logic        empty;
        logic        last;
    } t_queue_result;

    // shadow copy of the queue contents, limit register and owed result words
    class aging_fifo;
        t_rec            store[DEPTH];
        int unsigned     held;
        logic [7:0]      limit;
        t_queue_result   owed[$];
        int unsigned     errors;

        function new();
            held = 0;
            limit = TIMEOUT_RESET;
            errors = 0;
        endfunction

        function void owe(t_kind kind, t_rec rec, logic last);
            t_queue_result r;
            r.kind = kind;
            r.rec = rec;
            r.occ = 5'(held);
            r.empty = (held == 0);
            r.last = last;
            owed.push_back(r);
        endfunction

        // apply one accepted input word and queue up the results it causes
        function void take_word(t_cmd cmd, t_rec rec);
            t_rec cur;
            t_rec blank;
            int unsigned kept;
            int unsigned n;
            blank = '0;
            case (cmd)
                CMD_PUSH: begin
                    if (held >= DEPTH) begin
                        owe(KIND_PUSH_FULL, blank, 1'b1);
                    end else begin
                        store[held] = rec;
                        held++;
                        owe(KIND_PUSH_OK, blank, 1'b1);
                    end
                end
                CMD_POP: begin
                    if (held == 0) begin
                        owe(KIND_POP_EMPTY, blank, 1'b1);
                    end else begin
                        cur = store[0];
                        for (int i = 1; i < held; i++) begin
                            store[i-1] = store[i];
                        end
                        held--;
                        owe(KIND_POPPED, cur, 1'b1);
                    end
                end
                CMD_TICK: begin
                    // age all, evict in queue order, survivors close up
                    kept = 0;
                    n = held;
                    for (int i = 0; i < n; i++) begin
                        cur = store[i];
                        if (cur.wait_cnt != 8'hFF) begin
                            cur.wait_cnt = cur.wait_cnt + 8'd1;
                        end
                        if (cur.wait_cnt >= limit) begin
                            held--;
                            owe(KIND_TIMEOUT, cur, 1'b0);
                        end else begin
                            store[kept] = cur;
                            kept++;
                        end
                    end
                    owe(KIND_TICK_DONE, blank, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one result word against the oldest owed one
        function void check_result(logic [2:0] kind, logic [OUT_DATA_W-1:0] data, logic last);
            t_queue_result want;
            t_rec got;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, expected none got kind %0d tdata %h",
                         $time, kind, data);
                errors++;
                return;
            end
            want = owed.pop_front();
            got = data[REC_W-1:0];
            compare_field("kind", want.kind, kind);
            compare_field("task_id", want.rec.task_id, got.task_id);
            compare_field("priority", want.rec.prio, got.prio);
            compare_field("remaining", want.rec.remaining, got.remaining);
            compare_field("wait", want.rec.wait_cnt, got.wait_cnt);
            compare_field("occupancy", want.occ, data[REC_W+OCC_W-1:REC_W]);
            compare_field("is_empty", want.empty, data[REC_W+OCC_W]);
            compare_field("last", want.last, last);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [1:0]            i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [2:0]            o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [7:0]            i_cfg_data;

    aging_fifo   fifo_copy;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_cnt;

    fifo_with_aging_timeout i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // check every result word taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            fifo_copy.check_result(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: done, errors");
        $finish;
    end

    function automatic t_rec rand_rec();
        t_rec r;
        r.task_id = 16'($urandom);
        r.prio = 3'($urandom);
        r.remaining = 16'($urandom);
        // mostly young records, some at any age
        if ($urandom_range(0, 3) == 0) begin
            r.wait_cnt = 8'($urandom_range(0, 255));
        end else begin
            r.wait_cnt = 8'($urandom_range(0, 12));
        end
        return r;
    endfunction

    function automatic t_rec make_rec(logic [15:0] id, logic [2:0] prio,
                                      logic [15:0] rem, logic [7:0] waited);
        t_rec r;
        r.task_id = id;
        r.prio = prio;
        r.remaining = rem;
        r.wait_cnt = waited;
        return r;
    endfunction

    // present one word, called and returning at a falling edge
    task automatic send_word(input t_cmd cmd, input t_rec rec);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata = {{(IN_DATA_W-REC_W){1'b0}}, rec};
        i_s_axis_tuser = cmd;
        i_s_axis_tvalid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        fifo_copy.take_word(cmd, rec);
        @(negedge i_clk);
    endtask

    // stop sending and wait until every owed word has come back
    task automatic drain_queue();
        i_s_axis_tvalid = 1'b0;
        while (fifo_copy.owed.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        fifo_copy.limit = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_phase(input int unsigned n_items, input logic [7:0] lim,
                                input int unsigned s_pct, input int unsigned r_pct);
        int unsigned sent;
        int unsigned pick;
        drain_queue();
        write_limit(lim);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                send_word(CMD_PUSH, rand_rec());
                sent++;
            end else if (pick < 58) begin
                send_word(CMD_POP, rand_rec());
                sent++;
            end else if (pick < 86) begin
                send_word(CMD_TICK, rand_rec());
                sent++;
            end else if (pick < 91) begin
                // ignored command, not counted
                send_word(CMD_NONE, rand_rec());
            end else begin
                // fill the queue past capacity
                for (int k = 0; k < BURST_PUSHES; k++) begin
                    send_word(CMD_PUSH, rand_rec());
                end
                sent += BURST_PUSHES;
            end
        end
    endtask

    initial begin
        fifo_copy = new();
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = CMD_PUSH;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        send_idle_pct = 10;
        recv_idle_pct = 53;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed, reset limit of 21
        send_word(CMD_POP, '0);
        send_word(CMD_TICK, '0);
        send_word(CMD_NONE, '1);
        send_word(CMD_PUSH, make_rec(16'h0000, 3'd0, 16'h0000, 8'd0));
        send_word(CMD_PUSH, make_rec(16'hFFFF, 3'd7, 16'hFFFF, 8'd255));
        send_word(CMD_PUSH, make_rec(16'h1234, 3'd5, 16'h0001, 8'd20));
        send_word(CMD_PUSH, make_rec(16'hA5A5, 3'd2, 16'h5A5A, 8'd21));
        send_word(CMD_PUSH, make_rec(16'h0F0F, 3'd3, 16'hF0F0, 8'd3));
        // saturated, just-reached and pushed-old entries go, the rest close up
        send_word(CMD_TICK, '0);
        send_word(CMD_POP, '0);
        send_word(CMD_POP, '0);
        send_word(CMD_POP, '0);

        // limit of zero: every entry goes on the next tick
        drain_queue();
        write_limit(8'd0);
        send_word(CMD_PUSH, rand_rec());
        send_word(CMD_PUSH, make_rec(16'h8001, 3'd4, 16'h7FFE, 8'd0));
        send_word(CMD_TICK, '0);
        send_word(CMD_POP, '0);

        // top limit: only a count that reaches 255 after aging times out
        drain_queue();
        write_limit(8'd255);
        send_word(CMD_PUSH, make_rec(16'h00FF, 3'd1, 16'h0100, 8'd254));
        send_word(CMD_PUSH, make_rec(16'hFF00, 3'd6, 16'h00FF, 8'd255));
        send_word(CMD_PUSH, make_rec(16'h5555, 3'd5, 16'hAAAA, 8'd100));
        send_word(CMD_TICK, '0);
        send_word(CMD_POP, '0);

        random_phase(135, 8'd4, 10, 53);
        random_phase(135, 8'd255, 53, 10);
        random_phase(135, 8'($urandom_range(5, 40)), 0, 0);

        drain_queue();
        if (fifo_copy.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/fwat_pkg.sv
rtl/fwat_ram.sv
rtl/fwat_dp.sv
rtl/fwat_ctrl.sv
rtl/fifo_with_aging_timeout.sv
rtl/fwat_checker.sv
tb/tb.sv
